// File: hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the RTL.
// Both expect the signal clk to be in scope; PCS_ASSERT also expects rst_n.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define PCS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define PCS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/pcs_pkg.sv
// ---------------------------------------------------------------------------
// pcs_pkg
// Character codes, scanner modes and beat types for the comment stripper.
// ---------------------------------------------------------------------------
package pcs_pkg;

    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_QUOTE  = 8'h27;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_NL     = 8'h0A;

    typedef enum logic [8:0] {
        MODE_CODE       = 9'b000000001,
        MODE_HELD_PAREN = 9'b000000010,
        MODE_HELD_SLASH = 9'b000000100,
        MODE_BRACE      = 9'b000001000,
        MODE_PAREN      = 9'b000010000,
        MODE_PAREN_STAR = 9'b000100000,
        MODE_LINE       = 9'b001000000,
        MODE_STRING     = 9'b010000000,
        MODE_STRING_Q   = 9'b100000000
    } mode_t;

    // One output beat.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       run_last;
        logic       text_end;
    } res_t;

    // Beats produced by one input byte: count (0..2) and up to two beats.
    typedef struct packed {
        logic [1:0] num;
        res_t       r0;
        res_t       r1;
    } scan_out_t;

endpackage

// File: hdl/pcs_scan.sv
// ---------------------------------------------------------------------------
// pcs_scan
// Scanner state and the per-byte decode into zero, one or two beats.
// ---------------------------------------------------------------------------
module pcs_scan
    import pcs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       take,
    input  logic [7:0] in_byte,
    input  logic       is_last,
    output scan_out_t  res
);

    typedef struct packed {
        logic  emit;
        mode_t mode;
    } code_step_t;

    mode_t mode_reg;
    mode_t mode_next;

    // Plain code-mode handling of one character.
    function automatic code_step_t code_byte(input logic [7:0] c);
        code_step_t s;
        s.emit = 1'b0;
        s.mode = MODE_CODE;
        if (c == CH_LBRACE) begin
            s.mode = MODE_BRACE;
        end else if (c == CH_LPAREN) begin
            s.mode = MODE_HELD_PAREN;
        end else if (c == CH_QUOTE) begin
            s.emit = 1'b1;
            s.mode = MODE_STRING;
        end else if (c == CH_SLASH) begin
            s.mode = MODE_HELD_SLASH;
        end else begin
            s.emit = 1'b1;
        end
        return s;
    endfunction

    code_step_t cb;
    logic       pre_en;
    logic [7:0] pre_ch;
    logic       mid_en;
    logic       fl_en;
    logic [7:0] fl_ch;
    mode_t      mode_mid;
    logic [1:0] num;
    logic [7:0] e0;
    logic [7:0] e1;

    always_comb
    begin
        cb       = code_byte(in_byte);
        pre_en   = 1'b0;
        pre_ch   = CH_LPAREN;
        mid_en   = 1'b0;
        mode_mid = mode_reg;
        unique case (mode_reg)
            MODE_HELD_PAREN:
            begin
                if (in_byte == CH_STAR) begin
                    mode_mid = MODE_PAREN;
                end else begin
                    pre_en   = 1'b1;
                    mid_en   = cb.emit;
                    mode_mid = cb.mode;
                end
            end
            MODE_HELD_SLASH:
            begin
                pre_ch = CH_SLASH;
                if (in_byte == CH_SLASH) begin
                    mode_mid = MODE_LINE;
                end else begin
                    pre_en   = 1'b1;
                    mid_en   = cb.emit;
                    mode_mid = cb.mode;
                end
            end
            MODE_BRACE:
            begin
                if (in_byte == CH_RBRACE) begin
                    mode_mid = MODE_CODE;
                end
            end
            MODE_PAREN:
            begin
                if (in_byte == CH_STAR) begin
                    mode_mid = MODE_PAREN_STAR;
                end
            end
            MODE_PAREN_STAR:
            begin
                if (in_byte == CH_RPAREN) begin
                    mode_mid = MODE_CODE;
                end else if (in_byte != CH_STAR) begin
                    mode_mid = MODE_PAREN;
                end
            end
            MODE_LINE:
            begin
                if (in_byte == CH_NL) begin
                    mid_en   = 1'b1;
                    mode_mid = MODE_CODE;
                end
            end
            MODE_STRING:
            begin
                mid_en = 1'b1;
                if (in_byte == CH_QUOTE) begin
                    mode_mid = MODE_STRING_Q;
                end
            end
            MODE_STRING_Q:
            begin
                if (in_byte == CH_QUOTE) begin
                    mid_en   = 1'b1;
                    mode_mid = MODE_STRING;
                end else begin
                    mid_en   = cb.emit;
                    mode_mid = cb.mode;
                end
            end
            default:
            begin
                // code mode and any stray code
                mid_en   = cb.emit;
                mode_mid = cb.mode;
            end
        endcase

        // flush a held paren or slash at text end
        fl_en = is_last && ((mode_mid == MODE_HELD_PAREN) || (mode_mid == MODE_HELD_SLASH));
        fl_ch = (mode_mid == MODE_HELD_PAREN) ? CH_LPAREN : CH_SLASH;

        // pack into at most two slots, in emit order
        num = 2'd0;
        e0  = 8'h00;
        e1  = 8'h00;
        if (pre_en) begin
            e0  = pre_ch;
            num = 2'd1;
        end
        if (mid_en) begin
            if (num == 2'd0) begin
                e0 = in_byte;
            end else begin
                e1 = in_byte;
            end
            num = num + 2'd1;
        end
        if (fl_en && (num != 2'd2)) begin
            if (num == 2'd0) begin
                e0 = fl_ch;
            end else begin
                e1 = fl_ch;
            end
            num = num + 2'd1;
        end

        mode_next = is_last ? MODE_CODE : mode_mid;

        res.r0.out_byte   = e0;
        res.r0.byte_valid = (num != 2'd0);
        res.r0.run_last   = (num != 2'd2);
        res.r0.text_end   = is_last && (num != 2'd2);
        res.r1.out_byte   = e1;
        res.r1.byte_valid = 1'b1;
        res.r1.run_last   = 1'b1;
        res.r1.text_end   = is_last;
        // end-only marker when the last byte leaves nothing to send
        res.num = (is_last && (num == 2'd0)) ? 2'd1 : num;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg <= MODE_CODE;
        end else if (take) begin
            mode_reg <= mode_next;
        end
    end

endmodule

// File: hdl/pcs_outq.sv
// ---------------------------------------------------------------------------
// pcs_outq
// Two-slot result buffer between the scanner and the output channel.
// ---------------------------------------------------------------------------
module pcs_outq
    import pcs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  scan_out_t push_data,
    input  logic      out_stall,
    output logic      out_valid,
    output res_t      head,
    output logic      room
);

    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    res_t       slot0_reg;
    res_t       slot0_next;
    res_t       slot1_reg;
    res_t       slot1_next;
    logic       pop;

    assign out_valid = (cnt_reg != 2'd0);
    assign head      = slot0_reg;
    assign pop       = out_valid && !out_stall;
    // room for a worst-case pair once this cycle's pop is done
    assign room      = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && !out_stall);

    always_comb
    begin
        cnt_next   = cnt_reg;
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        if (push) begin
            slot0_next = push_data.r0;
            slot1_next = push_data.r1;
            cnt_next   = push_data.num;
        end else if (pop) begin
            slot0_next = slot1_reg;
            cnt_next   = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

endmodule

// File: hdl/pascal_comment_stripper.sv
// ---------------------------------------------------------------------------
// pascal_comment_stripper
// Removes brace, paren-star and slash-slash comments from Pascal source.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one source byte per beat, is_last
//   set on the final byte of a text. Output channel (out_valid / out_stall):
//   one kept byte per beat with byte_valid, run_last (last beat caused by
//   this input byte) and text_end (final beat of the text). A text that ends
//   with nothing to send still yields one beat with byte_valid low.
//   Latency: a beat shows on the output the cycle after its byte is taken.
//   Throughput: one byte per cycle while the buffer has room. A byte that
//   yields two beats (a held '(' or '/' released together with the current
//   char) stalls input until the two-slot buffer drains a beat via one port.
//   Reset: scanner returns to plain code mode, buffer empties.
//   When the receiver stalls, the head beat holds; the input stalls as soon
//   as the buffer cannot take another worst-case pair.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module pascal_comment_stripper
    import pcs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       is_last,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       byte_valid,
    output logic       run_last,
    output logic       text_end
);

    scan_out_t scan_res;
    res_t      head;
    logic      room;
    logic      take;

    assign in_stall = !room;
    assign take     = in_valid && room;

    // scanner: state machine plus per-byte decode
    pcs_scan u_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .take    (take),
        .in_byte (in_byte),
        .is_last (is_last),
        .res     (scan_res)
    );

    // result buffer decouples the receiver's stalls from the scanner
    pcs_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (take),
        .push_data (scan_res),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .head      (head),
        .room      (room)
    );

    assign out_byte   = head.out_byte;
    assign byte_valid = head.byte_valid;
    assign run_last   = head.run_last;
    assign text_end   = head.text_end;

    // the final byte of a text always produces a beat
    `PCS_ASSERT(a_last_gives_beat, (in_valid && !in_stall && is_last) |=> out_valid, "last byte gave no beat")
    // end-only marker carries a zero byte and closes the text
    `PCS_ASSERT(a_marker_shape, (out_valid && !byte_valid) |-> (text_end && run_last && out_byte == 8'h00), "bad end marker")
    // text end is always the last beat of its byte
    `PCS_ASSERT(a_end_is_run_last, (out_valid && text_end) |-> run_last, "text_end without run_last")
    // an empty buffer never holds off the sender
    `PCS_ASSERT_ALWAYS(a_empty_accepts, (rst_n && !out_valid) |-> !in_stall, "stall with empty buffer")

endmodule

// File: tb/pascal_comment_stripper_test.sv
// ----------------------------------------------------------------------------
// pascal_comment_stripper_test
// Self-checking bench for the Pascal comment stripper. A scoreboard class
// tracks the scanner mode on its own and queues the beats that each accepted
// source byte should give. Directed texts cover the corner cases. Random
// texts follow, built mostly from real comments, strings and code with some
// broken pieces and raw bytes mixed in. Both channels idle at random.
// ----------------------------------------------------------------------------
module pascal_comment_stripper_test
    import pcs_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_BYTES = 650;
    localparam int DRAIN_CYCLES = 20;      // output shows in the cycle after intake
    localparam int CYCLE_LIMIT  = 400000;
    localparam int PRINT_CAP    = 40;

    // ------------------------------------------------------------------------
    // Scoreboard: mirrors the scanner and holds the beats still owed.
    // ------------------------------------------------------------------------
    class kept_text_board;
        mode_t      scan_state;
        res_t       kept_beats[$];
        logic [7:0] step_bytes[$];   // bytes released by the current source byte
        int         errors;
        int         beats_checked;
        int         pair_bytes;
        int         end_markers;
        int         texts_done;

        function new();
            scan_state    = MODE_CODE;
            errors        = 0;
            beats_checked = 0;
            pair_bytes    = 0;
            end_markers   = 0;
            texts_done    = 0;
        endfunction

        // Append one released byte for the current source byte.
        function void add_step(logic [7:0] c);
            step_bytes = {step_bytes, c};
        endfunction

        // Append one owed beat.
        function void add_beat(res_t b);
            kept_beats = {kept_beats, b};
        endfunction

        // A character seen in plain code.
        function void code_char(logic [7:0] c);
            case (c)
                CH_LBRACE: scan_state = MODE_BRACE;
                CH_LPAREN: scan_state = MODE_HELD_PAREN;
                CH_SLASH:  scan_state = MODE_HELD_SLASH;
                CH_QUOTE:
                begin
                    add_step(c);
                    scan_state = MODE_STRING;
                end
                default:
                begin
                    add_step(c);
                    scan_state = MODE_CODE;
                end
            endcase
        endfunction

        // Accepted source byte: advance the mode and queue the beats it owes.
        function void note_byte(logic [7:0] c, logic last);
            res_t beat;
            step_bytes.delete();
            case (scan_state)
                MODE_HELD_PAREN:
                begin
                    if (c == CH_STAR)
                        scan_state = MODE_PAREN;
                    else
                    begin
                        add_step(CH_LPAREN);
                        code_char(c);
                    end
                end
                MODE_HELD_SLASH:
                begin
                    if (c == CH_SLASH)
                        scan_state = MODE_LINE;
                    else
                    begin
                        add_step(CH_SLASH);
                        code_char(c);
                    end
                end
                MODE_BRACE:
                begin
                    if (c == CH_RBRACE)
                        scan_state = MODE_CODE;
                end
                MODE_PAREN:
                begin
                    if (c == CH_STAR)
                        scan_state = MODE_PAREN_STAR;
                end
                MODE_PAREN_STAR:
                begin
                    if (c == CH_RPAREN)
                        scan_state = MODE_CODE;
                    else if (c != CH_STAR)
                        scan_state = MODE_PAREN;
                end
                MODE_LINE:
                begin
                    if (c == CH_NL)
                    begin
                        add_step(CH_NL);
                        scan_state = MODE_CODE;
                    end
                end
                MODE_STRING:
                begin
                    add_step(c);
                    if (c == CH_QUOTE)
                        scan_state = MODE_STRING_Q;
                end
                MODE_STRING_Q:
                begin
                    if (c == CH_QUOTE)
                    begin
                        add_step(c);
                        scan_state = MODE_STRING;
                    end
                    else
                        code_char(c);
                end
                default: code_char(c);
            endcase

            // End of text flushes a held '(' or '/', then back to code.
            if (last)
            begin
                if (scan_state == MODE_HELD_PAREN)
                    add_step(CH_LPAREN);
                else if (scan_state == MODE_HELD_SLASH)
                    add_step(CH_SLASH);
                scan_state = MODE_CODE;
                texts_done++;
            end

            if (last && step_bytes.size() == 0)
            begin
                beat = '{8'h00, 1'b0, 1'b1, 1'b1};
                add_beat(beat);
                end_markers++;
            end
            else
            begin
                if (step_bytes.size() == 2)
                    pair_bytes++;
                foreach (step_bytes[k])
                begin
                    beat.out_byte   = step_bytes[k];
                    beat.byte_valid = 1'b1;
                    beat.run_last   = (k == step_bytes.size() - 1);
                    beat.text_end   = beat.run_last && last;
                    add_beat(beat);
                end
            end
        endfunction

        task report(string msg);
            errors++;
            if (errors <= PRINT_CAP)
                $display("[%0t] mismatch: %s", $time, msg);
        endtask

        // Accepted output beat against the oldest owed beat.
        task check_beat(logic [7:0] b, logic bv, logic rl, logic te);
            res_t want;
            beats_checked++;
            if (kept_beats.size() == 0)
                report($sformatf("unexpected beat byte=%02h valid=%b", b, bv));
            else
            begin
                want = kept_beats.pop_front();
                if (b !== want.out_byte)
                    report($sformatf("out_byte %02h, want %02h", b, want.out_byte));
                if (bv !== want.byte_valid)
                    report($sformatf("byte_valid %b, want %b", bv, want.byte_valid));
                if (rl !== want.run_last)
                    report($sformatf("run_last %b, want %b", rl, want.run_last));
                if (te !== want.text_end)
                    report($sformatf("text_end %b, want %b", te, want.text_end));
            end
        endtask
    endclass

    // ------------------------------------------------------------------------
    // DUT and its signals
    // ------------------------------------------------------------------------
    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] in_byte;
    logic       is_last;
    logic       out_valid;
    logic       out_stall;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       run_last;
    logic       text_end;

    pascal_comment_stripper DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_byte    (in_byte),
        .is_last    (is_last),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_byte   (out_byte),
        .byte_valid (byte_valid),
        .run_last   (run_last),
        .text_end   (text_end)
    );

    kept_text_board kept;
    logic [7:0]     text[$];        // source text being sent
    int             bytes_sent;
    int             cycle_count = 0;
    bit             in_quiet;       // sender runs back to back while set
    bit             out_quiet;      // receiver never stalls while set

    // Append one byte to the source text.
    function void text_add(logic [7:0] c);
        text = {text, c};
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("pascal_comment_stripper_test NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Source side
    // ------------------------------------------------------------------------

    // One source beat. The idle gap is drawn per byte; now and then the
    // sender flips into a stretch with no gaps at all. Signals are sampled
    // right after the edge, so in_stall is the value the DUT saw.
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        if ($urandom_range(0, 31) == 0)
            in_quiet = !in_quiet;
        gap = in_quiet ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        is_last  <= last;
        do
            @(posedge clk);
        while (in_stall);
        kept.note_byte(b, last);
        bytes_sent++;
    endtask

    // Whole text, is_last on its final byte.
    task automatic send_text();
        foreach (text[i])
            send_byte(text[i], i == text.size() - 1);
    endtask

    function void load(string s);
        text.delete();
        foreach (s[i])
            text_add(s[i]);
    endfunction

    // Mostly lowercase and blanks inside comments and strings, sometimes any byte.
    function logic [7:0] body_char();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6)
            return 8'h61 + 8'($urandom_range(0, 25));
        else if (r < 8)
            return 8'h20;
        else
            return 8'($urandom_range(0, 255));
    endfunction

    function logic [7:0] code_pick();
        string pool;
        pool = "abqXYZ019 ;:=.\n";
        return pool[$urandom_range(0, pool.len() - 1)];
    endfunction

    function logic [7:0] special_pick();
        string pool;
        pool = "{}(*)'/\n";
        return pool[$urandom_range(0, pool.len() - 1)];
    endfunction

    // Random text from a handful of pieces. About one closer in seven is
    // dropped so that unclosed comments and strings reach the text end too.
    function void build_random_text();
        int         pieces;
        logic [7:0] ch;
        text.delete();
        pieces = $urandom_range(1, 8);
        repeat (pieces)
        begin
            case ($urandom_range(0, 9))
                0, 1:
                    repeat ($urandom_range(1, 6)) text_add(code_pick());
                2:
                begin
                    text_add(CH_LBRACE);
                    repeat ($urandom_range(0, 6)) text_add(body_char());
                    if ($urandom_range(0, 6) != 0)
                        text_add(CH_RBRACE);
                end
                3:
                begin
                    text_add(CH_LPAREN);
                    text_add(CH_STAR);
                    repeat ($urandom_range(0, 5))
                    begin
                        ch = ($urandom_range(0, 4) == 0) ? CH_STAR : body_char();
                        text_add(ch);
                    end
                    repeat ($urandom_range(1, 3)) text_add(CH_STAR);
                    if ($urandom_range(0, 6) != 0)
                        text_add(CH_RPAREN);
                end
                4:
                begin
                    text_add(CH_SLASH);
                    text_add(CH_SLASH);
                    repeat ($urandom_range(0, 6))
                    begin
                        ch = body_char();
                        text_add(ch == CH_NL ? 8'h20 : ch);
                    end
                    if ($urandom_range(0, 6) != 0)
                        text_add(CH_NL);
                end
                5:
                begin
                    text_add(CH_QUOTE);
                    repeat ($urandom_range(0, 5))
                    begin
                        ch = ($urandom_range(0, 3) == 0) ? CH_QUOTE : body_char();
                        // a quote inside a string goes in doubled
                        if (ch == CH_QUOTE)
                            text_add(CH_QUOTE);
                        text_add(ch);
                    end
                    if ($urandom_range(0, 6) != 0)
                        text_add(CH_QUOTE);
                end
                6:
                begin
                    text_add($urandom_range(0, 1) ? CH_LPAREN : CH_SLASH);
                    text_add(special_pick());
                end
                7:
                    text_add(special_pick());
                default:
                    text_add(8'($urandom_range(0, 255)));
            endcase
        end
    endfunction

    // ------------------------------------------------------------------------
    // Sink side: draws a stall per beat, checks every accepted beat.
    // ------------------------------------------------------------------------
    initial
    begin
        int hold;
        out_stall = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if ($urandom_range(0, 31) == 0)
                out_quiet = !out_quiet;
            hold = out_quiet ? 0 : $urandom_range(0, 15);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!out_valid);
            kept.check_beat(out_byte, byte_valid, run_last, text_end);
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        kept        = new();
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_byte     = 8'h00;
        is_last     = 1'b0;
        bytes_sent  = 0;
        in_quiet    = 1'b0;
        out_quiet   = 1'b0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed texts.
        load("(");      send_text();    // held paren flushed at text end
        load("/");      send_text();    // held slash flushed at text end
        load("'a'");    send_text();    // text ends on a possible closing quote
        load("{x");     send_text();    // unclosed brace comment: end marker only
        load("//c");    send_text();    // line comment with no newline
        load("(*)*)");  send_text();    // ')' right after "(*" stays in the comment
        load("(**)");   send_text();    // star run before ')' closes it
        load("/(");                     // slash released, paren held, then both go
        text_add(8'h00);
        send_text();
        load("'''");                    // doubled quote, then unclosed string
        text_add(8'hFF);
        send_text();

        // Random texts.
        while (bytes_sent < RANDOM_BYTES + 23)
        begin
            build_random_text();
            send_text();
        end
        in_valid <= 1'b0;

        // Drain: owed beats first, then a short tail for strays.
        while (kept.kept_beats.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d source bytes in %0d texts, %0d beats checked", bytes_sent,
                 kept.texts_done, kept.beats_checked);
        $display("%0d bytes released two beats, %0d texts closed by a bare end marker",
                 kept.pair_bytes, kept.end_markers);
        if (kept.errors == 0)
            $display("pascal_comment_stripper_test OK");
        else
            $display("pascal_comment_stripper_test NOT OK");
        $finish;
    end

endmodule
